// ===== hdl/ozone_frame_parser_averager_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ozone frame parser and averager.
// Concurrent checks in simulation, empty bodies when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef OZONE_FRAME_PARSER_AVERAGER_UNIT_ASSERT_SVH
`define OZONE_FRAME_PARSER_AVERAGER_UNIT_ASSERT_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define OFPA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define OFPA_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define OFPA_ASSERT(label, clk, rst_n, prop, msg)
`define OFPA_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// ===== hdl/ofpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ofpa_pkg
// Shared types and constants of the ozone frame parser and averager.
// ----------------------------------------------------------------------------
package ofpa_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IDX_GAS   = 2'd0;
    localparam logic [1:0] CFG_IDX_UNIT  = 2'd1;
    localparam logic [1:0] CFG_IDX_INSTR = 2'd2;

    // Configuration reset values.
    localparam logic [7:0] GAS_CODE_RST   = 8'h2A;
    localparam logic [7:0] UNIT_CODE_RST  = 8'h04;
    localparam logic [7:0] INSTR_CODE_RST = 8'h00;

    // First byte of every frame.
    localparam logic [7:0] HDR_BYTE = 8'hFF;

    // Largest value shown on the 16-bit result fields.
    localparam logic [15:0] SHOW_MAX = 16'hFFFF;

    // Request from the sequencer to the parser for one accepted item.
    typedef struct packed {
        logic       take;
        logic       cmd;
        logic [7:0] rx_byte;
    } t_parse_req;

    // Parser status of the last item.
    typedef struct packed {
        logic        good;
        logic        bad;
        logic [15:0] conc;
    } t_parse_rsp;

endpackage

// ===== hdl/ofpa_ifs.sv =====
// ----------------------------------------------------------------------------
// ofpa_ifs
// Valid/ready channels of the ozone frame parser and averager.
// ----------------------------------------------------------------------------
interface ofpa_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface ofpa_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] average;
    logic [15:0] samples;
    logic        frame_good;
    logic        checksum_error;
    logic        overflow;

    modport source (output valid, output average, output samples, output frame_good,
                    output checksum_error, output overflow, input ready);
    modport sink   (input valid, input average, input samples, input frame_good,
                    input checksum_error, input overflow, output ready);
endinterface

interface ofpa_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/ofpa_divider.sv =====
// ----------------------------------------------------------------------------
// ofpa_divider
// Restoring divider, one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module ofpa_divider #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] diff;
    logic             borrow;

    // Shift in the next numerator bit and try to subtract the divisor.
    always_comb begin
        shifted = {r_rem, r_quo[NUM_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_den};
        borrow  = diff[DEN_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_rem  <= '0;
                r_den  <= i_den;
                r_quo  <= i_num;
            end else if (r_busy) begin
                r_rem <= borrow ? shifted[DEN_W-1:0] : diff[DEN_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], ~borrow};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== hdl/ofpa_parser.sv =====
// ----------------------------------------------------------------------------
// ofpa_parser
// Byte-wise parser of the 9-byte sensor frame with running checksum.
// ----------------------------------------------------------------------------
module ofpa_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ofpa_pkg::t_parse_req i_req,
    input  logic [7:0]          i_gas_code,
    input  logic [7:0]          i_unit_code,
    input  logic [7:0]          i_instr_code,
    output ofpa_pkg::t_parse_rsp o_rsp
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAS,
        ST_UNIT,
        ST_INSTR,
        ST_CONC_HI,
        ST_CONC_LO,
        ST_RANGE_HI,
        ST_RANGE_LO,
        ST_CHECK
    } t_parse_state;

    t_parse_state r_state;
    logic [7:0]   r_sum;
    logic [15:0]  r_conc;
    logic         r_good;
    logic         r_bad;

    logic [7:0] rx;
    assign rx = i_req.rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sum   <= '0;
            r_conc  <= '0;
            r_good  <= 1'b0;
            r_bad   <= 1'b0;
        end else if (i_req.take) begin
            r_good <= 1'b0;
            r_bad  <= 1'b0;
            // A restart command leaves the parser alone.
            if (!i_req.cmd) begin
                unique case (r_state)
                    ST_GAS: begin
                        if (rx == i_gas_code) begin
                            r_sum   <= r_sum + rx;
                            r_state <= ST_UNIT;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                    ST_UNIT: begin
                        if (rx == i_unit_code) begin
                            r_sum   <= r_sum + rx;
                            r_state <= ST_INSTR;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                    ST_INSTR: begin
                        if (rx == i_instr_code) begin
                            r_sum   <= r_sum + rx;
                            r_state <= ST_CONC_HI;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                    ST_CONC_HI: begin
                        r_sum   <= r_sum + rx;
                        r_conc  <= {rx, 8'h00};
                        r_state <= ST_CONC_LO;
                    end
                    ST_CONC_LO: begin
                        r_sum   <= r_sum + rx;
                        r_conc  <= {r_conc[15:8], rx};
                        r_state <= ST_RANGE_HI;
                    end
                    ST_RANGE_HI: begin
                        r_sum   <= r_sum + rx;
                        r_state <= ST_RANGE_LO;
                    end
                    ST_RANGE_LO: begin
                        r_sum   <= r_sum + rx;
                        r_state <= ST_CHECK;
                    end
                    ST_CHECK: begin
                        if (~r_sum == rx) begin
                            r_good <= 1'b1;
                        end else begin
                            r_bad <= 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                    default: begin
                        if (rx == ofpa_pkg::HDR_BYTE) begin
                            r_sum   <= rx;
                            r_state <= ST_GAS;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                endcase
            end
        end
    end

    assign o_rsp.good = r_good;
    assign o_rsp.bad  = r_bad;
    assign o_rsp.conc = r_conc;

endmodule

// ===== hdl/ozone_frame_parser_averager_unit.sv =====
// ----------------------------------------------------------------------------
// ozone_frame_parser_averager_unit
// Ozone sensor frame parser with saturating accumulator and averager.
// ----------------------------------------------------------------------------
// Usage:
// Each item on i_in is either one received serial byte (cmd 0) or a restart
// command (cmd 1) that clears the running total and the sample count.
// Every item produces exactly one result item on o_out with the current
// average (total divided by count, 0 with no samples, shown saturated at
// 65535), the sample count and the frame status flags of that byte.
// The header codes are set through i_cfg, index 0 gas, 1 unit, 2 instruction;
// writes to other indexes are ignored. Write them only while the unit is idle.
// Sequence: an accepted item passes through S_ACC, S_LOAD, S_DIV and S_DONE; the
// restoring divider works at one quotient bit per cycle in S_DIV. The unit takes no
// new item while one is in flight; i_in takes the next
// item once the result sits in the output register, so a stalled receiver
// holds the unit only once a second result is ready to be stored.
// Reset (synchronous, active low) clears the parser, the accumulators, the
// output valid flag and restores the default header codes.
// ----------------------------------------------------------------------------
`include "ozone_frame_parser_averager_unit_assert.svh"

module ozone_frame_parser_averager_unit #(
    parameter int SUM_WIDTH   = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ofpa_in_if.sink     i_in,
    ofpa_cfg_if.sink    i_cfg,
    ofpa_out_if.source  o_out
);

    // Width that holds the sample count and the largest shown value.
    localparam int CW_EXT = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 17;

    // Sequencer: take an item, update the accumulators, run the divider,
    // then hand the result to the output register.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_LOAD,
        S_DIV,
        S_DONE
    } t_seq_state;

    t_seq_state r_state;

    // Configuration registers.
    logic [7:0] r_gas_code;
    logic [7:0] r_unit_code;
    logic [7:0] r_instr_code;

    // Accumulators.
    logic [SUM_WIDTH-1:0]   r_total;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                   r_ovf;

    // Output register.
    logic        r_o_valid;
    logic [15:0] r_o_average;
    logic [15:0] r_o_samples;
    logic        r_o_good;
    logic        r_o_bad;
    logic        r_o_ovf;

    logic                   in_take;
    ofpa_pkg::t_parse_req   parse_req;
    ofpa_pkg::t_parse_rsp   parse_rsp;
    logic                   div_start;
    logic                   div_done;
    logic [SUM_WIDTH-1:0]   div_quo;
    logic [SUM_WIDTH:0]     sum_ext;
    logic                   acc_full;
    logic [15:0]            avg_show;
    logic [CW_EXT-1:0]      count_ext;
    logic [15:0]            count_show;

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_take     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign parse_req.take    = in_take;
    assign parse_req.cmd     = i_in.cmd;
    assign parse_req.rx_byte = i_in.rx_byte;

    ofpa_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (parse_req),
        .i_gas_code   (r_gas_code),
        .i_unit_code  (r_unit_code),
        .i_instr_code (r_instr_code),
        .o_rsp        (parse_rsp)
    );

    assign div_start = (r_state == S_LOAD);

    ofpa_divider #(
        .NUM_W (SUM_WIDTH),
        .DEN_W (COUNT_WIDTH)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_total),
        .i_den   (r_count),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // A good frame is dropped when its concentration would carry the total
    // past its width, or when the sample count already sits at its maximum.
    always_comb begin
        sum_ext  = {1'b0, r_total} + (SUM_WIDTH + 1)'(parse_rsp.conc);
        acc_full = (&r_count) || sum_ext[SUM_WIDTH];
    end

    // Shown values saturate at the 16-bit maximum; no samples means average 0.
    always_comb begin
        if (r_count == '0) begin
            avg_show = '0;
        end else if (|div_quo[SUM_WIDTH-1:16]) begin
            avg_show = ofpa_pkg::SHOW_MAX;
        end else begin
            avg_show = div_quo[15:0];
        end
        count_ext = CW_EXT'(r_count);
        if (count_ext > CW_EXT'(ofpa_pkg::SHOW_MAX)) begin
            count_show = ofpa_pkg::SHOW_MAX;
        end else begin
            count_show = count_ext[15:0];
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gas_code   <= ofpa_pkg::GAS_CODE_RST;
            r_unit_code  <= ofpa_pkg::UNIT_CODE_RST;
            r_instr_code <= ofpa_pkg::INSTR_CODE_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                ofpa_pkg::CFG_IDX_GAS:   r_gas_code   <= i_cfg.data;
                ofpa_pkg::CFG_IDX_UNIT:  r_unit_code  <= i_cfg.data;
                ofpa_pkg::CFG_IDX_INSTR: r_instr_code <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Sequencer, accumulators and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_total   <= '0;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            // The output register fills from S_DONE and empties when the
            // receiver takes the result.
            if ((r_state == S_DONE) && (!r_o_valid || o_out.ready)) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_ovf   <= 1'b0;
                        if (i_in.cmd) begin
                            r_total <= '0;
                            r_count <= '0;
                        end
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (parse_rsp.good) begin
                        if (acc_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_total <= sum_ext[SUM_WIDTH-1:0];
                            r_count <= r_count + 1'b1;
                        end
                    end
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_o_valid || o_out.ready) begin
                        r_o_average <= avg_show;
                        r_o_samples <= count_show;
                        r_o_good    <= parse_rsp.good;
                        r_o_bad     <= parse_rsp.bad;
                        r_o_ovf     <= r_ovf;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid          = r_o_valid;
    assign o_out.average        = r_o_average;
    assign o_out.samples        = r_o_samples;
    assign o_out.frame_good     = r_o_good;
    assign o_out.checksum_error = r_o_bad;
    assign o_out.overflow       = r_o_ovf;

    // A dropped frame is always a frame with a good checksum.
    `OFPA_NEVER(a_ovf_needs_good, i_clk, i_rst_n, o_out.valid && o_out.overflow && !o_out.frame_good, "overflow without good frame")
    // A frame cannot be both good and bad.
    `OFPA_NEVER(a_good_bad_excl, i_clk, i_rst_n, o_out.valid && o_out.frame_good && o_out.checksum_error, "good and bad frame at once")
    // The sample count only steps up by one or restarts from zero.
    `OFPA_ASSERT(a_count_step, i_clk, i_rst_n, (r_count != $past(r_count)) |-> ((r_count == $past(r_count) + 1'b1) || (r_count == '0)), "sample count jumped")
    // The divider finishes only while the sequencer waits for it.
    `OFPA_ASSERT(a_div_done_state, i_clk, i_rst_n, div_done |-> (r_state == S_DIV), "divider done outside wait state")

endmodule
